// ----- hw/rtl/svang_pkg.sv -----
`timescale 1ns / 1ps
// svang_pkg: widths, the sideband record and the CORDIC arctangent table
// shared by every stage of signed_vector_angle. No dependencies.
package svang_pkg;

  localparam int COMPONENT_BITS = 16;
  localparam int ANGLE_BITS     = 16;

  // configuration register
  localparam int TOL_BITS   = 16;
  localparam logic [TOL_BITS-1:0] TOL_RESET = 16'd1074;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] IDX_TOL = 1'b0;

  // normalization: largest magnitude lands in [2^TOP_BIT, 2^(TOP_BIT+1))
  localparam int TOP_BIT  = 30;
  localparam int MAG_W    = COMPONENT_BITS + 1;
  localparam int SHIFT_W  = $clog2(TOP_BIT + 1);
  localparam int SCALE_W  = TOP_BIT + 3;
  localparam int PROD_W   = 64;
  localparam int DOT_W    = PROD_W + 2;
  localparam int HALF_W   = PROD_W / 2;

  // square root, divider, CORDIC
  localparam int RAD_W        = 64;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int ROOT_STEPS   = RAD_W / 2;
  localparam int CMAG_W       = TOP_BIT + 1;
  localparam int DIV_STEPS    = CMAG_W;
  localparam int DIVIDEND_W   = HALF_W + TOP_BIT;
  localparam int CORDIC_STEPS = 32;
  localparam int CORDIC_W     = 36;
  localparam int TURN_W       = 33;

  typedef logic signed [COMPONENT_BITS-1:0] comp_t;
  typedef comp_t [2:0] vec_t;

  // what travels beside the arithmetic through the long stages
  typedef struct packed {
    logic              deg;
    logic              xneg;
    logic              dneg;
    logic              par;
    logic              anti;
    logic [HALF_W-1:0] dmag;
    logic [CMAG_W-1:0] cmag;
  } svang_side_t;

  // arctangent of 2^-k in units of 2^-32 turn
  function automatic logic [31:0] atan_turns(input logic [4:0] k);
    logic [31:0] v;
    case (k)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      5'd28: v = 32'd3;
      5'd29: v = 32'd1;
      5'd30: v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hw/rtl/signed_vector_angle.sv -----
`timescale 1ns / 1ps
// signed_vector_angle: top level, configuration register and the pipeline.
// Uses svang_pkg, svang_front, svang_sqrt, svang_div and svang_cordic.
//
// Gives the rotation angle from a first to a second signed 3-vector as a
// fraction of a full turn, with a flag for a zero-length vector. One vector
// pair is taken every clock cycle while the pipeline is not held. It has 6
// front-end stages, 32 stages per square root twice, 34 for the divider and
// cosine tests and 34 for the CORDIC and rounding. The whole pipeline holds
// when the output item is not taken, so in_ready follows out_ready while
// the output register is full. Register 0 at byte address 0 holds the
// parallel tolerance in bits 15:0 and should be written only while no item
// is in flight.
module signed_vector_angle (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_first_x,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_first_y,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_first_z,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_second_x,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_second_y,
  input  logic signed [svang_pkg::COMPONENT_BITS-1:0] in_second_z,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [svang_pkg::ANGLE_BITS-1:0]        out_angle_turns,
  output logic                                    out_degenerate,
  input  logic                                    cfg_psel,
  input  logic                                    cfg_penable,
  input  logic                                    cfg_pwrite,
  input  logic [svang_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  logic [svang_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [svang_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                    cfg_pready
);
  import svang_pkg::*;

  logic                en;
  logic [TOL_BITS-1:0] tol_r;
  logic                cfg_hit;
  vec_t                a_vec, b_vec;

  logic              f_vld, r1_vld, d_vld, r2_vld;
  logic [RAD_W-1:0]  f_prod, d_rad;
  logic [ROOT_W-1:0] r1_root, r2_root;
  svang_side_t       f_side, r1_side, d_side, r2_side;

  // configuration register
  assign cfg_pready = 1'b1;
  assign cfg_hit    = cfg_paddr[CFG_ADDR_W-1:2] == IDX_TOL;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      tol_r <= cfg_pwdata[TOL_BITS-1:0];
    end
  end

  assign cfg_prdata = cfg_hit ? CFG_DATA_W'(tol_r) : '0;

  // advance the pipeline unless a finished item waits
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  assign a_vec = {in_first_z, in_first_y, in_first_x};
  assign b_vec = {in_second_z, in_second_y, in_second_x};

  svang_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_valid),
    .a_i    (a_vec),
    .b_i    (b_vec),
    .vld_o  (f_vld),
    .prod_o (f_prod),
    .side_o (f_side)
  );

  svang_sqrt u_len_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .rad_i  (f_prod),
    .side_i (f_side),
    .vld_o  (r1_vld),
    .root_o (r1_root),
    .side_o (r1_side)
  );

  svang_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .tol_i  (tol_r),
    .vld_i  (r1_vld),
    .root_i (r1_root),
    .side_i (r1_side),
    .vld_o  (d_vld),
    .rad_o  (d_rad),
    .side_o (d_side)
  );

  svang_sqrt u_sin_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (d_vld),
    .rad_i  (d_rad),
    .side_i (d_side),
    .vld_o  (r2_vld),
    .root_o (r2_root),
    .side_o (r2_side)
  );

  svang_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (r2_vld),
    .sine_i  (r2_root),
    .side_i  (r2_side),
    .vld_o   (out_valid),
    .angle_o (out_angle_turns),
    .deg_o   (out_degenerate)
  );

endmodule

// ----- hw/rtl/svang_front.sv -----
`timescale 1ns / 1ps
// svang_front: input capture, per-vector normalization, squared lengths, dot
// product and the product of squared lengths. Six stages. Uses svang_pkg.
module svang_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                vld_i,
  input  svang_pkg::vec_t                     a_i,
  input  svang_pkg::vec_t                     b_i,
  output logic                                vld_o,
  output logic [svang_pkg::RAD_W-1:0]         prod_o,
  output svang_pkg::svang_side_t              side_o
);
  import svang_pkg::*;

  // left shift that brings the largest magnitude up to bit TOP_BIT
  function automatic logic [SHIFT_W-1:0] norm_shift(input vec_t v);
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] mi;
    logic [SHIFT_W-1:0] p;
    m = '0;
    p = '0;
    for (int i = 0; i < 3; i++) begin
      mi = v[i][COMPONENT_BITS-1] ? MAG_W'(-$signed({v[i][COMPONENT_BITS-1], v[i]}))
                                  : {1'b0, v[i]};
      if (mi > m) m = mi;
    end
    for (int k = 0; k < MAG_W; k++) begin
      if (m[k]) p = SHIFT_W'(k);
    end
    return SHIFT_W'(TOP_BIT) - p;
  endfunction

  // stage 1: capture
  logic v1_r;
  vec_t a1_r, b1_r;

  // stage 2: shift amounts, zero test, cross terms
  logic v2_r, deg2_r;
  vec_t a2_r, b2_r;
  logic [SHIFT_W-1:0] sa2_r, sb2_r;
  logic signed [2*COMPONENT_BITS-1:0] c1_2_r, c2_2_r;

  // stage 3: scaled vectors
  logic v3_r, deg3_r, xneg3_r;
  logic signed [SCALE_W-1:0] a3_r [3];
  logic signed [SCALE_W-1:0] b3_r [3];

  // stage 4: element products
  logic v4_r, deg4_r, xneg4_r;
  logic [PROD_W-1:0] aa4_r [3];
  logic [PROD_W-1:0] bb4_r [3];
  logic signed [PROD_W-1:0] ab4_r [3];

  // stage 5: sums
  logic v5_r, deg5_r, xneg5_r, dneg5_r;
  logic [HALF_W-1:0] na5_r, nb5_r, dmag5_r;

  // stage 6: product of squared lengths
  logic v6_r;
  logic [RAD_W-1:0] prod6_r;
  svang_side_t side6_r;

  logic [PROD_W-1:0] na_sum, nb_sum;
  logic signed [DOT_W-1:0] dot_sum, dot_mag;
  svang_side_t side_nxt;

  always_comb begin
    na_sum  = aa4_r[0] + aa4_r[1] + aa4_r[2];
    nb_sum  = bb4_r[0] + bb4_r[1] + bb4_r[2];
    dot_sum = DOT_W'(ab4_r[0]) + DOT_W'(ab4_r[1]) + DOT_W'(ab4_r[2]);
    dot_mag = dot_sum[DOT_W-1] ? -dot_sum : dot_sum;
    side_nxt      = '0;
    side_nxt.deg  = deg5_r;
    side_nxt.xneg = xneg5_r;
    side_nxt.dneg = dneg5_r;
    side_nxt.dmag = dmag5_r;
  end

  // advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_i;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  // advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= a_i;
      b1_r <= b_i;

      a2_r   <= a1_r;
      b2_r   <= b1_r;
      sa2_r  <= norm_shift(a1_r);
      sb2_r  <= norm_shift(b1_r);
      deg2_r <= (a1_r == '0) || (b1_r == '0);
      c1_2_r <= a1_r[0] * b1_r[2];
      c2_2_r <= a1_r[2] * b1_r[0];

      deg3_r  <= deg2_r;
      xneg3_r <= c1_2_r < c2_2_r;
      for (int i = 0; i < 3; i++) begin
        a3_r[i] <= SCALE_W'(a2_r[i]) <<< sa2_r;
        b3_r[i] <= SCALE_W'(b2_r[i]) <<< sb2_r;
      end

      deg4_r  <= deg3_r;
      xneg4_r <= xneg3_r;
      for (int i = 0; i < 3; i++) begin
        aa4_r[i] <= PROD_W'(a3_r[i] * a3_r[i]);
        bb4_r[i] <= PROD_W'(b3_r[i] * b3_r[i]);
        ab4_r[i] <= PROD_W'(a3_r[i] * b3_r[i]);
      end

      deg5_r  <= deg4_r;
      xneg5_r <= xneg4_r;
      dneg5_r <= dot_sum[DOT_W-1];
      na5_r   <= na_sum[PROD_W-1:HALF_W];
      nb5_r   <= nb_sum[PROD_W-1:HALF_W];
      dmag5_r <= dot_mag[PROD_W-1:HALF_W];

      prod6_r <= RAD_W'(na5_r * nb5_r);
      side6_r <= side_nxt;
    end
  end

  assign vld_o  = v6_r;
  assign prod_o = prod6_r;
  assign side_o = side6_r;

endmodule

// ----- hw/rtl/svang_sqrt.sv -----
`timescale 1ns / 1ps
// svang_sqrt: pipelined integer square root, one result bit per stage,
// with the sideband record carried alongside. Uses svang_pkg.
module svang_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic [svang_pkg::RAD_W-1:0]   rad_i,
  input  svang_pkg::svang_side_t        side_i,
  output logic                          vld_o,
  output logic [svang_pkg::ROOT_W-1:0]  root_o,
  output svang_pkg::svang_side_t        side_o
);
  import svang_pkg::*;

  logic              v_r    [ROOT_STEPS];
  logic [RAD_W-1:0]  n_r    [ROOT_STEPS];
  logic [RAD_W-1:0]  r_r    [ROOT_STEPS];
  svang_side_t       side_r [ROOT_STEPS];

  for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_stage
    localparam logic [RAD_W-1:0] BIT = RAD_W'(1) << (RAD_W - 2 - 2 * k);
    logic             v_in;
    logic [RAD_W-1:0] n_in, r_in, trial;
    svang_side_t      s_in;

    if (k == 0) begin : g_first
      assign v_in = vld_i;
      assign n_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign n_in = n_r[k-1];
      assign r_in = r_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign trial = r_in + BIT;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    // take the trial bit when the remainder allows it
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_in;
        if (n_in >= trial) begin
          n_r[k] <= n_in - trial;
          r_r[k] <= (r_in >> 1) + BIT;
        end else begin
          n_r[k] <= n_in;
          r_r[k] <= r_in >> 1;
        end
      end
    end
  end

  assign vld_o  = v_r[ROOT_STEPS-1];
  assign root_o = r_r[ROOT_STEPS-1][ROOT_W-1:0];
  assign side_o = side_r[ROOT_STEPS-1];

endmodule

// ----- hw/rtl/svang_div.sv -----
`timescale 1ns / 1ps
// svang_div: cosine magnitude by restoring long division, clamp, tolerance
// tests and the radicand 1 - cos^2 for the sine root. Uses svang_pkg.
module svang_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            en,
  input  logic [svang_pkg::TOL_BITS-1:0]  tol_i,
  input  logic                            vld_i,
  input  logic [svang_pkg::ROOT_W-1:0]    root_i,
  input  svang_pkg::svang_side_t          side_i,
  output logic                            vld_o,
  output logic [svang_pkg::RAD_W-1:0]     rad_o,
  output svang_pkg::svang_side_t          side_o
);
  import svang_pkg::*;

  localparam logic [CMAG_W-1:0] ONE     = CMAG_W'(1) << TOP_BIT;
  localparam logic [RAD_W-1:0]  ONE_SQ  = RAD_W'(1) << (2 * TOP_BIT);

  logic                  v_r    [DIV_STEPS];
  logic [DIVIDEND_W-1:0] rem_r  [DIV_STEPS];
  logic [CMAG_W-1:0]     q_r    [DIV_STEPS];
  logic [ROOT_W-1:0]     den_r  [DIV_STEPS];
  logic                  ovf_r  [DIV_STEPS];
  svang_side_t           side_r [DIV_STEPS];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_stage
    localparam int SH = DIV_STEPS - 1 - k;
    logic                  v_in, ovf_in;
    logic [DIVIDEND_W-1:0] rem_in, cand;
    logic [CMAG_W-1:0]     q_in;
    logic [ROOT_W-1:0]     den_in;
    svang_side_t           s_in;

    if (k == 0) begin : g_first
      assign v_in   = vld_i;
      assign rem_in = {side_i.dmag, TOP_BIT'(0)};
      assign q_in   = '0;
      assign den_in = root_i;
      // quotient would need more than CMAG_W bits: clamp later
      assign ovf_in = {1'b0, side_i.dmag} >= {root_i, 1'b0};
      assign s_in   = side_i;
    end else begin : g_next
      assign v_in   = v_r[k-1];
      assign rem_in = rem_r[k-1];
      assign q_in   = q_r[k-1];
      assign den_in = den_r[k-1];
      assign ovf_in = ovf_r[k-1];
      assign s_in   = side_r[k-1];
    end

    assign cand = DIVIDEND_W'(den_in) << SH;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    // subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (en) begin
        den_r[k]  <= den_in;
        ovf_r[k]  <= ovf_in;
        side_r[k] <= s_in;
        if (!ovf_in && (rem_in >= cand)) begin
          rem_r[k] <= rem_in - cand;
          q_r[k]   <= q_in | (CMAG_W'(1) << SH);
        end else begin
          rem_r[k] <= rem_in;
          q_r[k]   <= q_in;
        end
      end
    end
  end

  // clamp and tolerance stage
  logic              vc_r;
  svang_side_t       sc_r;
  // square stage
  logic              vs_r;
  logic [RAD_W-1:0]  sq_r;
  svang_side_t       ss_r;
  // radicand stage
  logic              vr_r;
  logic [RAD_W-1:0]  rad_r;
  svang_side_t       sr_r;

  logic [CMAG_W-1:0] cmag;
  logic [31:0]       near_plus, near_minus, tol_ext;
  svang_side_t       sc_nxt;

  always_comb begin
    sc_nxt = side_r[DIV_STEPS-1];
    if (ovf_r[DIV_STEPS-1] || (q_r[DIV_STEPS-1] > ONE)) begin
      cmag = ONE;
    end else begin
      cmag = q_r[DIV_STEPS-1];
    end
    // distance of the signed cosine from +1 and from -1
    near_plus  = sc_nxt.dneg ? 32'(ONE) + 32'(cmag) : 32'(ONE) - 32'(cmag);
    near_minus = sc_nxt.dneg ? 32'(ONE) - 32'(cmag) : 32'(ONE) + 32'(cmag);
    tol_ext    = 32'(tol_i);
    sc_nxt.cmag = cmag;
    sc_nxt.par  = near_plus <= tol_ext;
    sc_nxt.anti = near_minus <= tol_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vs_r <= 1'b0;
      vr_r <= 1'b0;
    end else if (en) begin
      vc_r <= v_r[DIV_STEPS-1];
      vs_r <= vc_r;
      vr_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sc_r  <= sc_nxt;
      sq_r  <= RAD_W'(sc_r.cmag * sc_r.cmag);
      ss_r  <= sc_r;
      rad_r <= ONE_SQ - sq_r;
      sr_r  <= ss_r;
    end
  end

  assign vld_o  = vr_r;
  assign rad_o  = rad_r;
  assign side_o = sr_r;

endmodule

// ----- hw/rtl/svang_cordic.sv -----
`timescale 1ns / 1ps
// svang_cordic: vectoring CORDIC for atan2(sine, cosine) in turns, then
// clamp, reflection, special cases and rounding. Uses svang_pkg.
module svang_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic [svang_pkg::ROOT_W-1:0]       sine_i,
  input  svang_pkg::svang_side_t             side_i,
  output logic                               vld_o,
  output logic [svang_pkg::ANGLE_BITS-1:0]   angle_o,
  output logic                               deg_o
);
  import svang_pkg::*;

  localparam logic signed [CORDIC_W-1:0] QUARTER = CORDIC_W'(1) << 30;
  localparam logic signed [CORDIC_W-1:0] HALF    = CORDIC_W'(1) << 31;
  localparam logic [TURN_W-1:0] HALF_T   = TURN_W'(1) << 31;
  localparam logic [TURN_W-1:0] FULL_T   = TURN_W'(1) << 32;
  localparam logic [TURN_W-1:0] ROUND_T  = TURN_W'(1) << (31 - ANGLE_BITS);

  // start stage: rotate a negative cosine by a quarter turn
  logic                       v0_r;
  logic signed [CORDIC_W-1:0] x0_r, y0_r, z0_r;
  svang_side_t                s0_r;
  logic signed [CORDIC_W-1:0] cs;

  assign cs = side_i.dneg ? -CORDIC_W'(side_i.cmag) : CORDIC_W'(side_i.cmag);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_r <= side_i;
      if (cs < 0) begin
        x0_r <= CORDIC_W'(sine_i);
        y0_r <= -cs;
        z0_r <= QUARTER;
      end else begin
        x0_r <= cs;
        y0_r <= CORDIC_W'(sine_i);
        z0_r <= '0;
      end
    end
  end

  logic                       v_r    [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] x_r    [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] y_r    [CORDIC_STEPS];
  logic signed [CORDIC_W-1:0] z_r    [CORDIC_STEPS];
  svang_side_t                side_r [CORDIC_STEPS];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_stage
    logic                       v_in;
    logic signed [CORDIC_W-1:0] x_in, y_in, z_in, dx, dy, at;
    svang_side_t                s_in;

    if (k == 0) begin : g_first
      assign v_in = v0_r;
      assign x_in = x0_r;
      assign y_in = y0_r;
      assign z_in = z0_r;
      assign s_in = s0_r;
    end else begin : g_next
      assign v_in = v_r[k-1];
      assign x_in = x_r[k-1];
      assign y_in = y_r[k-1];
      assign z_in = z_r[k-1];
      assign s_in = side_r[k-1];
    end

    assign dx = y_in >>> k;
    assign dy = x_in >>> k;
    assign at = CORDIC_W'(atan_turns(5'(k)));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    // rotate toward the x axis and track the angle
    always_ff @(posedge clk) begin
      if (en) begin
        side_r[k] <= s_in;
        if (y_in > 0) begin
          x_r[k] <= x_in + dx;
          y_r[k] <= y_in - dy;
          z_r[k] <= z_in + at;
        end else begin
          x_r[k] <= x_in - dx;
          y_r[k] <= y_in + dy;
          z_r[k] <= z_in - at;
        end
      end
    end
  end

  // finish: clamp, reflect, special cases, round
  logic                       vf_r;
  logic [ANGLE_BITS-1:0]      angle_r;
  logic                       deg_r;
  logic signed [CORDIC_W-1:0] zl;
  logic [TURN_W-1:0]          turns, rounded;
  svang_side_t                sl;

  always_comb begin
    zl = z_r[CORDIC_STEPS-1];
    sl = side_r[CORDIC_STEPS-1];
    if (zl < 0) begin
      turns = '0;
    end else if (zl > HALF) begin
      turns = HALF_T;
    end else begin
      turns = zl[TURN_W-1:0];
    end
    if (sl.xneg) begin
      turns = FULL_T - turns;
    end
    if (sl.par) begin
      turns = '0;
    end else if (sl.anti) begin
      turns = HALF_T;
    end
    rounded = turns + ROUND_T;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= v_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      deg_r   <= sl.deg;
      angle_r <= sl.deg ? '0 : rounded[31 -: ANGLE_BITS];
    end
  end

  assign vld_o   = vf_r;
  assign angle_o = angle_r;
  assign deg_o   = deg_r;

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking bench for signed_vector_angle, with directed, sweep,
// random and backpressure tests against a bit-exact angle predictor.
// Depends on svang_pkg and the signed_vector_angle RTL.
module tb_top;
  import svang_pkg::*;

  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 160;
  localparam logic [CFG_ADDR_W-1:0] ADDR_TOL    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] ADDR_UNUSED = 3'd4;

  typedef struct packed {
    logic [ANGLE_BITS-1:0] angle;
    logic                  deg;
  } angle_res_t;

  typedef struct packed {
    comp_t ax, ay, az, bx, by, bz;
  } vec_pair_t;

  // arctangent of 2^-k, in 2^-32 turn
  localparam longint ATAN_Q32 [32] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
    10, 5, 3, 1, 1, 0};

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  comp_t in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z;
  logic [ANGLE_BITS-1:0] out_angle_turns;
  logic out_degenerate;
  logic cfg_psel, cfg_penable, cfg_pwrite, cfg_pready;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata, cfg_prdata;

  logic [TOL_BITS-1:0] tol_shadow;
  angle_res_t expected_angles[$];
  int errors;
  int cycle_count;
  int gap_max;       // largest idle gap either side draws
  int hold_len;      // long receiver hold-off, consumed once

  signed_vector_angle u_top (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [63:0] isqrt64(input logic [63:0] n);
    logic [63:0] r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt >>= 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // shift that brings the largest magnitude into [2^30, 2^31)
  function automatic int norm_shift(input longint v0, input longint v1, input longint v2);
    longint m;
    int s;
    m = v0 < 0 ? -v0 : v0;
    if ((v1 < 0 ? -v1 : v1) > m) m = v1 < 0 ? -v1 : v1;
    if ((v2 < 0 ? -v2 : v2) > m) m = v2 < 0 ? -v2 : v2;
    s = 0;
    while (m < (64'sd1 << 30)) begin
      m <<= 1;
      s++;
    end
    return s;
  endfunction

  function automatic angle_res_t predict_angle(input vec_pair_t v,
                                               input logic [TOL_BITS-1:0] tol);
    longint a[3], b[3], sa[3], sb[3];
    longint p, cs, x, y, z, dx, dy, t, one, tl;
    logic [63:0] na, nb, pos, neg, dmag, rt, cmag, turns;
    logic dneg;
    int i, shf_a, shf_b;
    angle_res_t res;
    a[0] = v.ax; a[1] = v.ay; a[2] = v.az;
    b[0] = v.bx; b[1] = v.by; b[2] = v.bz;
    res = '0;
    // zero-length vector: flag, angle 0
    if ((a[0] == 0 && a[1] == 0 && a[2] == 0) || (b[0] == 0 && b[1] == 0 && b[2] == 0)) begin
      res.deg = 1'b1;
      return res;
    end
    one = 64'sd1 << 30;
    tl = longint'({48'd0, tol});
    shf_a = norm_shift(a[0], a[1], a[2]);
    shf_b = norm_shift(b[0], b[1], b[2]);
    na = 0; nb = 0; pos = 0; neg = 0;
    for (i = 0; i < 3; i++) begin
      sa[i] = a[i] <<< shf_a;
      sb[i] = b[i] <<< shf_b;
      p = sa[i] * sb[i];
      na += 64'(sa[i] * sa[i]);
      nb += 64'(sb[i] * sb[i]);
      if (p < 0) neg += 64'(-p);
      else pos += 64'(p);
    end
    dneg = neg > pos;
    dmag = (dneg ? neg - pos : pos - neg) >> 32;
    rt = isqrt64((na >> 32) * (nb >> 32));
    cmag = (dmag << 30) / rt;
    if (cmag > 64'(one)) cmag = 64'(one);
    cs = dneg ? -longint'(cmag) : longint'(cmag);
    if (one - cs <= tl) begin
      turns = 0;
    end else if (cs + one <= tl) begin
      turns = 64'd1 << 31;
    end else begin
      x = cs;
      y = longint'(isqrt64((64'd1 << 60) - cmag * cmag));
      z = 0;
      // rotate a negative cosine by a quarter turn first
      if (x < 0) begin
        t = x;
        x = y;
        y = -t;
        z = one;
      end
      for (i = 0; i < 32; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += ATAN_Q32[i];
        end else begin
          x -= dx; y += dy; z -= ATAN_Q32[i];
        end
      end
      if (z < 0) z = 0;
      if (z > (64'sd1 << 31)) z = 64'sd1 << 31;
      turns = 64'(z);
      // reflect when the cross term is negative
      if (a[0] * b[2] < a[2] * b[0]) turns = (64'd1 << 32) - turns;
    end
    turns = (turns + (64'd1 << (31 - ANGLE_BITS))) >> (32 - ANGLE_BITS);
    res.angle = turns[ANGLE_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // predict each accepted item
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_angles.push_back(predict_angle({in_first_x, in_first_y, in_first_z,
                                               in_second_x, in_second_y, in_second_z},
                                              tol_shadow));
  end

  // check each accepted result against the oldest expectation
  always @(posedge clk) begin
    angle_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("result with no item pending", out_angle_turns, -1);
      end else begin
        want = expected_angles.pop_front();
        if (out_angle_turns !== want.angle)
          report_mismatch("angle_turns", out_angle_turns, want.angle);
        if (out_degenerate !== want.deg)
          report_mismatch("degenerate", out_degenerate, want.deg);
      end
    end
  end

  // receiver: random gaps, plus one long hold-off when asked
  initial begin
    int w;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      w = $urandom_range(0, gap_max);
      if (hold_len > 0) begin
        w = hold_len;
        hold_len = 0;
      end
      if (w > 0) begin
        out_ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!(out_valid && out_ready)) @(posedge clk);
    end
  end

  task automatic send_item(input vec_pair_t v);
    int w;
    w = $urandom_range(0, gap_max);
    if (w > 0) begin
      in_valid <= 1'b0;
      repeat (w) @(posedge clk);
    end
    {in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z} <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // wait until every expected result has come, then let the pipe empty
  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_angles.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_TOL) tol_shadow = data[TOL_BITS-1:0];
    // bus idle before the next transfer
    @(posedge clk);
  endtask

  function automatic comp_t clip(input longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return comp_t'(v);
  endfunction

  // mix of full-range, small, near-parallel, near-antiparallel and x-z plane pairs
  function automatic vec_pair_t random_pair();
    vec_pair_t v;
    int kind, nz;
    v = vec_pair_t'({$urandom, $urandom, $urandom});
    kind = $urandom_range(0, 9);
    nz = $urandom_range(0, 6);
    case (kind)
      0, 1, 2: ;
      3: begin
        v.ax = $urandom_range(0, 6) - 3; v.ay = $urandom_range(0, 6) - 3;
        v.az = $urandom_range(0, 6) - 3; v.bx = $urandom_range(0, 6) - 3;
        v.by = $urandom_range(0, 6) - 3; v.bz = $urandom_range(0, 6) - 3;
      end
      4, 5, 6: begin
        v.bx = clip(longint'(v.ax) + $urandom_range(0, 2 * nz) - nz);
        v.by = clip(longint'(v.ay) + $urandom_range(0, 2 * nz) - nz);
        v.bz = clip(longint'(v.az) + $urandom_range(0, 2 * nz) - nz);
      end
      7, 8: begin
        v.bx = clip(-longint'(v.ax) + $urandom_range(0, 2 * nz) - nz);
        v.by = clip(-longint'(v.ay) + $urandom_range(0, 2 * nz) - nz);
        v.bz = clip(-longint'(v.az) + $urandom_range(0, 2 * nz) - nz);
      end
      default: begin
        v.ay = 0; v.by = 0;
        if ($urandom_range(0, 1)) v.bz = 0;
      end
    endcase
    return v;
  endfunction

  task automatic test_directed;
    comp_t mx, mn;
    mx = 16'sd32767;
    mn = -16'sd32768;
    send_item('{0, 0, 0, 1, 2, 3});          // first vector zero
    send_item('{5, -7, 9, 0, 0, 0});         // second vector zero
    send_item('{0, 0, 0, 0, 0, 0});          // both zero
    send_item('{mx, mx, mx, mx, mx, mx});    // parallel at maximum
    send_item('{mn, mn, mn, mn, mn, mn});
    send_item('{mx, mx, mx, mn, mn, mn});    // antiparallel-ish extremes
    send_item('{mn, 0, 0, mx, 0, 0});
    send_item('{1, 0, 0, -1, 0, 0});         // exact half turn
    send_item('{1, 0, 0, 0, 0, 1});          // quarter, positive cross
    send_item('{1, 0, 0, 0, 0, -1});         // negative cross, reflected
    send_item('{0, 1, 0, 1, 0, 0});          // cross term zero
    send_item('{3, 4, 0, 3, 4, 0});
    send_item('{1, 1, 0, 1, 0, 0});
    send_item('{1, 0, 1, 1, 0, -1});
    send_item('{mx, 0, 1, mx, 0, -1});       // tiny angle, reflected
    send_item('{mn, 1, 0, mx, 0, 0});        // near antiparallel
    send_item('{mx, mn, 1, mn, mx, -1});
    send_item('{-1, -1, -1, 1, 1, 1});
    send_item('{0, 0, mn, 0, mx, 0});
    send_item('{mn, mx, 0, 0, 0, mn});
    drain();
  endtask

  task automatic test_tolerance_sweep;
    logic [31:0] tols[5];
    tols = '{32'h0, 32'hFFFF_FFFF, 32'h5A5A_0400, 32'h0001_0000, 32'd1074};
    foreach (tols[k]) begin
      cfg_write(ADDR_TOL, tols[k]);
      // a write to an unused index must leave the register alone
      cfg_write(ADDR_UNUSED, $urandom);
      repeat (60) send_item(random_pair());
      drain();
    end
  endtask

  task automatic test_random;
    for (int n = 0; n < 730; n++) begin
      // stretches with no idling at all
      gap_max = ((n / 150) % 3 == 1) ? 0 : 8;
      send_item(random_pair());
    end
    gap_max = 8;
    drain();
    cfg_write(ADDR_TOL, $urandom);
    repeat (100) send_item(random_pair());
    drain();
  endtask

  task automatic test_backpressure;
    gap_max = 0;
    hold_len = 400;
    repeat (200) send_item(random_pair());
    gap_max = 8;
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    {in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z} = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    tol_shadow = TOL_RESET;
    errors = 0;
    cycle_count = 0;
    gap_max = 8;
    hold_len = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_tolerance_sweep();
    test_random();
    test_backpressure();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
